[rtl/core/lpkc_pkg.sv]
// shared types and constants for the linear probe key counter
`timescale 1ns / 1ps

package lpkc_pkg;

	// table size, a power of two so the home slot is the low key bits
	localparam int TABLE_SLOTS = 1024;
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);

	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	// action codes
	localparam logic [1:0] ACT_COUNT = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [63:0] key;
		logic [9:0]  slot_index;
	} req_t;

	typedef struct packed {
		logic [9:0]  slot;
		logic [63:0] slot_key;
		logic [31:0] slot_count;
		logic        occupied;
		logic        table_full;
	} rsp_t;

	// one table entry as held in the memory
	typedef struct packed {
		logic        valid;
		logic [31:0] count;
		logic [63:0] key;
	} entry_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROBE,
		ST_READ,
		ST_RESULT
	} state_t;

endpackage

[rtl/core/linear_probe_key_counter.sv]
// linear probe key counter: open-addressing count table in one synchronous memory
`timescale 1ns / 1ps

// results pass res_q, then the rsp_q output register; count words probe on from the home slot
// clear word: sweeps every memory entry, one memory entry swept per cycle
// throughput: one word in flight; the next is taken once the result is in the output register
// the probe rate is one slot per cycle, set by the single read port of the table memory
// reset: asynchronous, then a clearing pass over all TABLE_SLOTS entries with req_stall high
module linear_probe_key_counter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  lpkc_pkg::req_t       req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output lpkc_pkg::rsp_t       rsp
);

	localparam logic [lpkc_pkg::SLOT_W-1:0] LAST_SLOT =
		lpkc_pkg::SLOT_W'(lpkc_pkg::TABLE_SLOTS - 1);

	// table memory: valid mark, count and key in one word
	lpkc_pkg::entry_t mem [lpkc_pkg::TABLE_SLOTS];

	lpkc_pkg::state_t state_q, state_d;

	// current word
	logic [63:0]                  key_q;
	logic [9:0]                   idx_q;
	logic [lpkc_pkg::SLOT_W-1:0]  pos_q;       // slot under test
	logic [lpkc_pkg::SLOT_W-1:0]  n_q;         // probes done so far
	logic [lpkc_pkg::SLOT_W-1:0]  clr_cnt_q;   // sweep pointer
	logic                         clr_reply_q; // sweep was asked for by a word
	lpkc_pkg::entry_t             rd_data_q;   // registered memory read
	lpkc_pkg::rsp_t               res_q;       // finished result before the output stage
	lpkc_pkg::rsp_t               rsp_q;
	logic                         rsp_valid_q;

	// memory port controls
	logic                         mem_we;
	logic [lpkc_pkg::SLOT_W-1:0]  mem_wa;
	lpkc_pkg::entry_t             mem_wd;
	logic [lpkc_pkg::SLOT_W-1:0]  mem_ra;

	logic                         res_load;
	lpkc_pkg::rsp_t               res_d;

	logic                         accept;
	logic                         hit;
	logic                         out_free;
	logic [31:0]                  new_count;
	logic                         idx_in_range;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != lpkc_pkg::ST_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// probe ends at an empty slot or at the slot that holds the key
	assign hit       = !rd_data_q.valid || (rd_data_q.key == key_q);
	// count saturates
	assign new_count = (rd_data_q.valid && rd_data_q.count == lpkc_pkg::COUNT_MAX) ?
		rd_data_q.count : ((rd_data_q.valid ? rd_data_q.count : 32'd0) + 32'd1);
	assign idx_in_range = (32'(idx_q) < 32'(lpkc_pkg::TABLE_SLOTS));

	// memory: at most one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_q <= mem[mem_ra];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lpkc_pkg::ST_CLEAR: begin
				if (clr_cnt_q == LAST_SLOT) begin
					state_d = clr_reply_q ? lpkc_pkg::ST_RESULT : lpkc_pkg::ST_IDLE;
				end
			end
			lpkc_pkg::ST_IDLE: begin
				if (accept) begin
					case (req.action)
						lpkc_pkg::ACT_COUNT: state_d = lpkc_pkg::ST_PROBE;
						lpkc_pkg::ACT_READ:  state_d = lpkc_pkg::ST_READ;
						lpkc_pkg::ACT_CLEAR: state_d = lpkc_pkg::ST_CLEAR;
						default:             state_d = lpkc_pkg::ST_RESULT;
					endcase
				end
			end
			lpkc_pkg::ST_PROBE: begin
				if (hit || n_q == LAST_SLOT) begin
					state_d = lpkc_pkg::ST_RESULT;
				end
			end
			lpkc_pkg::ST_READ: begin
				state_d = lpkc_pkg::ST_RESULT;
			end
			lpkc_pkg::ST_RESULT: begin
				if (out_free) begin
					state_d = lpkc_pkg::ST_IDLE;
				end
			end
			default: state_d = lpkc_pkg::ST_CLEAR;
		endcase
	end

	// memory controls and result word
	always_comb begin
		mem_we   = 1'b0;
		mem_wa   = pos_q;
		mem_wd   = '0;
		mem_ra   = pos_q + lpkc_pkg::SLOT_W'(1);
		res_load = 1'b0;
		res_d    = '0;
		case (state_q)
			lpkc_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_cnt_q;
				if (clr_cnt_q == LAST_SLOT) begin
					res_load = 1'b1;
				end
			end
			lpkc_pkg::ST_IDLE: begin
				// read issued with the word so the data is there next cycle
				if (req.action == lpkc_pkg::ACT_COUNT) begin
					mem_ra = req.key[lpkc_pkg::SLOT_W-1:0];
				end else begin
					mem_ra = lpkc_pkg::SLOT_W'(req.slot_index);
				end
				res_load = accept;
			end
			lpkc_pkg::ST_PROBE: begin
				if (hit) begin
					mem_we       = 1'b1;
					mem_wd.valid = 1'b1;
					mem_wd.count = new_count;
					mem_wd.key   = key_q;
					res_load         = 1'b1;
					res_d.slot       = 10'(pos_q);
					res_d.slot_key   = key_q;
					res_d.slot_count = new_count;
					res_d.occupied   = 1'b1;
				end else if (n_q == LAST_SLOT) begin
					res_load         = 1'b1;
					res_d.table_full = 1'b1;
				end
			end
			lpkc_pkg::ST_READ: begin
				res_load   = 1'b1;
				res_d.slot = idx_q;
				if (idx_in_range) begin
					res_d.slot_key   = rd_data_q.valid ? rd_data_q.key : 64'd0;
					res_d.slot_count = rd_data_q.count;
					res_d.occupied   = rd_data_q.valid;
				end
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lpkc_pkg::ST_CLEAR;
			clr_cnt_q   <= '0;
			clr_reply_q <= 1'b0;
			n_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lpkc_pkg::ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + lpkc_pkg::SLOT_W'(1);
			end else begin
				clr_cnt_q <= '0;
			end
			if (accept) begin
				clr_reply_q <= (req.action == lpkc_pkg::ACT_CLEAR);
			end
			if (accept) begin
				n_q <= '0;
			end else if (state_q == lpkc_pkg::ST_PROBE) begin
				n_q <= n_q + lpkc_pkg::SLOT_W'(1);
			end
			if (state_q == lpkc_pkg::ST_RESULT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= req.key;
			idx_q <= req.slot_index;
			pos_q <= req.key[lpkc_pkg::SLOT_W-1:0];
		end else if (state_q == lpkc_pkg::ST_PROBE && !hit) begin
			pos_q <= pos_q + lpkc_pkg::SLOT_W'(1);   // wraps at the table end
		end
		if (res_load) begin
			res_q <= res_d;
		end
		if (state_q == lpkc_pkg::ST_RESULT && out_free) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	// an accepted word always starts some work
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != lpkc_pkg::ST_IDLE))
		else $error("accepted word left the block idle");

	// a miss on the last probe reports a full table
	a_full_report: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lpkc_pkg::ST_PROBE && !hit && n_q == LAST_SLOT)
		|=> (state_q == lpkc_pkg::ST_RESULT && res_q.table_full))
		else $error("exhausted probe did not flag a full table");

	// a counted slot never reports a zero count
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lpkc_pkg::ST_PROBE && hit) |=> (res_q.slot_count != 32'd0))
		else $error("counted slot holds a zero count");

	// no result appears during a sweep
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lpkc_pkg::ST_CLEAR) |=> !$rose(rsp_valid))
		else $error("result raised during the clearing pass");
`endif

endmodule
